// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of the project.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bdq_pkg.sv =====
// Shared constants, types and helper functions for the bounded deque.
// No dependencies; imported by every module of the block but bdq_ram.
`default_nettype none

package bdq_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int SUM_W    = CNT_W + 1;
	localparam int FUNC_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int FILL_W   = 5;
	localparam int STATUS_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_CLEAR      = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_READ,
		CS_LOAD
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic update;   // apply the accepted operation to the ring
		logic load;     // capture the result into the output register
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_busy; // output register holds a transaction that is stalled
	} dp_status_t;

	// sum below twice the capacity, folded back into the ring
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = (s >= SUM_W'(CAPACITY)) ? (s - SUM_W'(CAPACITY)) : s;
		return r[IDX_W-1:0];
	endfunction

	function automatic logic [DATA_WIDTH-1:0] to_store(input logic signed [VALUE_W-1:0] v);
		return DATA_WIDTH'(v);
	endfunction

	function automatic logic signed [VALUE_W-1:0] to_out(input logic [DATA_WIDTH-1:0] d);
		return VALUE_W'($signed(d));
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bdq_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bdq_ctrl.sv =====
// Sequencing state machine for the bounded deque.
// Depends on bdq_pkg; drives bdq_dp through ctl_cmd_t.
`default_nettype none

module bdq_ctrl import bdq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire dp_status_t dp_sts,
	output ctl_cmd_t        cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_stall  = 1'b1;
		cmd.update = 1'b0;
		cmd.load   = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.update = 1'b1;
					state_d    = CS_READ;
				end
			end
			// ring read addresses settle; RAM samples them at the end of this cycle
			CS_READ: begin
				state_d = CS_LOAD;
			end
			CS_LOAD: begin
				if (!dp_sts.out_busy) begin
					cmd.load = 1'b1;
					state_d  = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/bdq_dp.sv =====
// Datapath of the bounded deque: ring pointers, entry RAM and output register.
// Depends on bdq_pkg and bdq_ram; commanded by bdq_ctrl.
`default_nettype none

module bdq_dp import bdq_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ctl_cmd_t                   cmd,
	output dp_status_t                      dp_sts,
	input  wire logic        [FUNC_W-1:0]   func,
	input  wire logic signed [VALUE_W-1:0]  push_value,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output logic signed      [VALUE_W-1:0]  front_value,
	output logic signed      [VALUE_W-1:0]  back_value,
	output logic                            is_empty,
	output logic             [FILL_W-1:0]   fill_count,
	output logic             [STATUS_W-1:0] status
);

	logic [IDX_W-1:0]    front_q;
	logic [CNT_W-1:0]    cnt_q;
	status_t             st_q;

	logic [IDX_W-1:0]    front_d;
	logic [CNT_W-1:0]    cnt_d;
	status_t             st_d;
	logic                push_ok;
	logic [IDX_W-1:0]    waddr;
	logic [IDX_W-1:0]    back_idx;
	logic                full;
	logic                empty;
	logic [DATA_WIDTH-1:0] rd_front;
	logic [DATA_WIDTH-1:0] rd_back;

	logic                      rsp_valid_q;
	logic signed [VALUE_W-1:0] front_value_q;
	logic signed [VALUE_W-1:0] back_value_q;
	logic                      is_empty_q;
	logic [FILL_W-1:0]         fill_count_q;
	logic [STATUS_W-1:0]       status_q;

	assign full  = (cnt_q == CNT_W'(CAPACITY));
	assign empty = (cnt_q == '0);

	// operation decode
	always_comb begin
		front_d = front_q;
		cnt_d   = cnt_q;
		st_d    = ST_OK;
		push_ok = 1'b0;
		waddr   = front_q;
		unique case (func)
			OP_PUSH_FRONT: begin
				if (full) begin
					st_d = ST_PUSH_FULL;
				end else begin
					front_d = (front_q == '0) ? IDX_W'(CAPACITY - 1) : (front_q - IDX_W'(1));
					waddr   = front_d;
					push_ok = 1'b1;
					cnt_d   = cnt_q + CNT_W'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					st_d = ST_PUSH_FULL;
				end else begin
					waddr   = wrap_idx(SUM_W'(front_q) + SUM_W'(cnt_q));
					push_ok = 1'b1;
					cnt_d   = cnt_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					st_d = ST_POP_EMPTY;
				end else begin
					front_d = (front_q == IDX_W'(CAPACITY - 1)) ? '0 : (front_q + IDX_W'(1));
					cnt_d   = cnt_q - CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					st_d = ST_POP_EMPTY;
				end else begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				front_d = '0;
				cnt_d   = '0;
			end
			default: begin
				// unused codes: no change
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			cnt_q   <= '0;
			st_q    <= ST_OK;
		end else if (cmd.update) begin
			front_q <= front_d;
			cnt_q   <= cnt_d;
			st_q    <= st_d;
		end
	end

	// back entry sits at front + count - 1; unused when empty
	assign back_idx = empty ? front_q
		: wrap_idx(SUM_W'(front_q) + SUM_W'(cnt_q) - SUM_W'(1));

	bdq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (cmd.update && push_ok),
		.waddr   (waddr),
		.wdata   (to_store(push_value)),
		.raddr_a (front_q),
		.raddr_b (back_idx),
		.rdata_a (rd_front),
		.rdata_b (rd_back)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			front_value_q <= empty ? '0 : to_out(rd_front);
			back_value_q  <= empty ? '0 : to_out(rd_back);
			is_empty_q    <= empty;
			fill_count_q  <= FILL_W'(cnt_q);
			status_q      <= st_q;
		end
	end

	assign dp_sts.out_busy = rsp_valid_q && rsp_stall;

	assign rsp_valid   = rsp_valid_q;
	assign front_value = front_value_q;
	assign back_value  = back_value_q;
	assign is_empty    = is_empty_q;
	assign fill_count  = fill_count_q;
	assign status      = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_double_ended_queue_top.sv =====
// Top level of the bounded double-ended queue (ring of CAPACITY entries).
// Depends on bdq_pkg, bdq_ctrl, bdq_dp and bdq_ram.
//
// Usage:
//  - Request channel (req_valid / req_stall, func, push_value): one
//    transaction per operation - push front, push back, pop front, pop back,
//    clear. Unused func codes leave the queue alone and report ST_OK.
//  - Response channel (rsp_valid / rsp_stall): exactly one transaction per
//    request, in order, carrying front and back values (zero when empty),
//    the empty flag, the fill count and a status code.
//  - Timing: a request taken at a clock edge updates the pointers and writes
//    the entry RAM at that edge; the RAM then reads front and back in
//    CS_READ, and the response is registered in CS_LOAD once the output
//    register is free. The request side takes no new transaction until then.
//  - A stalled response holds in the output register; the next request can
//    be taken meanwhile, and its result waits until the register frees.
//  - Reset (arst_n low, asynchronous) empties the queue and drops any
//    pending response. Entry contents are not cleared; only pushed entries
//    are ever read back.
`default_nettype none

module bounded_double_ended_queue_top import bdq_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_stall,
	input  wire logic        [FUNC_W-1:0]   func,
	input  wire logic signed [VALUE_W-1:0]  push_value,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output logic signed      [VALUE_W-1:0]  front_value,
	output logic signed      [VALUE_W-1:0]  back_value,
	output logic                            is_empty,
	output logic             [FILL_W-1:0]   fill_count,
	output logic             [STATUS_W-1:0] status
);

	ctl_cmd_t   cmd;
	dp_status_t dp_sts;

	// controller: accepts a transaction only when idle, sequences read and load
	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.dp_sts    (dp_sts),
		.cmd       (cmd)
	);

	// datapath: ring pointers, entry RAM, response register
	bdq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.dp_sts      (dp_sts),
		.func        (func),
		.push_value  (push_value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.front_value (front_value),
		.back_value  (back_value),
		.is_empty    (is_empty),
		.fill_count  (fill_count),
		.status      (status)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/bdq_checker.sv =====
// Port-level checker for the bounded deque, bound to the top level.
// Depends on bdq_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module bdq_checker import bdq_pkg::*; (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_stall,
	input wire logic signed [VALUE_W-1:0]  front_value,
	input wire logic signed [VALUE_W-1:0]  back_value,
	input wire logic                       is_empty,
	input wire logic        [FILL_W-1:0]   fill_count
);

	localparam logic COUNT_FITS = (CAPACITY < (1 << FILL_W));

	// empty flag and fill count agree
	`BDQ_ASSERT_NOW(a_empty_count, rsp_valid && COUNT_FITS, is_empty == (fill_count == '0), "empty flag disagrees with fill count")

	// an empty queue reports zero at both ends
	`BDQ_ASSERT_NOW(a_empty_zero, rsp_valid && is_empty, (front_value == '0) && (back_value == '0), "empty queue reports non-zero value")

	// a single entry is both front and back
	`BDQ_ASSERT_NOW(a_single_entry, rsp_valid && COUNT_FITS && (fill_count == FILL_W'(1)), front_value == back_value, "single entry differs at front and back")

	// stalled response holds
	`BDQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(front_value) && $stable(back_value) && $stable(fill_count), "stalled response changed")

endmodule

bind bounded_double_ended_queue_top bdq_checker u_bdq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.front_value (front_value),
	.back_value  (back_value),
	.is_empty    (is_empty),
	.fill_count  (fill_count)
);

`default_nettype wire
